/* design/npts_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// npts_pkg
// Shared types, sizes and arithmetic helpers for the nearest point table search.
// ----------------------------------------------------------------------------
package npts_pkg;

  localparam int TABLE_DEPTH = 256;
  localparam int COORD_WIDTH = 24;

  localparam int ADDR_W  = $clog2(TABLE_DEPTH);
  localparam int COUNT_W = $clog2(TABLE_DEPTH + 1);
  localparam int FUNC_W  = 2;
  localparam int INDEX_W = 8;
  localparam int STAT_W  = 2;
  localparam int ENTRY_W = 9;
  localparam int DIST_W  = 50;

  localparam int MAG_W   = COORD_WIDTH + 1;
  localparam int SQ_W    = 2 * MAG_W;
  localparam int SUM_W   = (SQ_W + 2 > DIST_W + 1) ? SQ_W + 2 : DIST_W + 1;
  localparam int POINT_W = 3 * COORD_WIDTH;

  localparam logic [DIST_W-1:0] DIST_MAX       = {DIST_W{1'b1}};
  localparam logic [DIST_W-1:0] MAX_DIST_RESET = DIST_W'(64'd65536000000000);

  typedef enum logic [FUNC_W-1:0] {
    FUNC_APPEND  = 2'd0,
    FUNC_REPLACE = 2'd1,
    FUNC_QUERY   = 2'd2,
    FUNC_NONE    = 2'd3
  } func_t;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK    = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_RANGE = 2'd2
  } status_t;

  typedef struct packed {
    logic [FUNC_W-1:0]             func;
    logic [INDEX_W-1:0]            index;
    logic signed [COORD_WIDTH-1:0] pos_x;
    logic signed [COORD_WIDTH-1:0] pos_y;
    logic signed [COORD_WIDTH-1:0] pos_z;
  } in_word_t;

  typedef struct packed {
    logic [STAT_W-1:0]  status;
    logic               found;
    logic [INDEX_W-1:0] found_index;
    logic [DIST_W-1:0]  best_distance;
    logic [ENTRY_W-1:0] entry_count;
  } out_word_t;

  function automatic logic [MAG_W-1:0] abs_diff(
    input logic [COORD_WIDTH-1:0] a,
    input logic [COORD_WIDTH-1:0] b
  );
    logic [MAG_W-1:0] d;
    d = {a[COORD_WIDTH-1], a} - {b[COORD_WIDTH-1], b};
    return d[MAG_W-1] ? (~d + MAG_W'(1)) : d;
  endfunction

  function automatic logic [DIST_W-1:0] sum_sat(
    input logic [SQ_W-1:0] a,
    input logic [SQ_W-1:0] b,
    input logic [SQ_W-1:0] c
  );
    logic [SUM_W-1:0] s;
    s = SUM_W'(a) + SUM_W'(b) + SUM_W'(c);
    return (s > SUM_W'(DIST_MAX)) ? DIST_MAX : s[DIST_W-1:0];
  endfunction

endpackage
`default_nettype wire

/* design/nearest_point_table_search.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nearest_point_table_search
// Point table in RAM with append, replace and a linear nearest point query.
// ----------------------------------------------------------------------------
//  channel   signals                    word
//  -------   -------------------------  -------------------------------
//  item      start / busy               func, index, pos_x/y/z
//  result    done (one cycle strobe)    status, found, found_index,
//                                       best_distance, entry_count
//  config    max_dist_we                max_dist_wdata (max_distance)
//
//  Append, replace and unused codes: result in the cycle after start, busy stays low.
//  Query: one RAM read per stored point, then a four stage distance pipeline
//  (diff, square, sum, compare); an empty table reads nothing.
//  rst is synchronous; it empties the table and restores max_distance.
//  The result is not held: it is valid only while done is high.
// ----------------------------------------------------------------------------
module nearest_point_table_search (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      start,
  output      logic                      busy,
  input  wire npts_pkg::in_word_t        item,
  output      logic                      done,
  output      npts_pkg::out_word_t       result,
  input  wire logic                      max_dist_we,
  input  wire logic [npts_pkg::DIST_W-1:0] max_dist_wdata
);

  import npts_pkg::*;

  typedef enum logic {
    ST_IDLE,
    ST_SCAN
  } state_t;

  state_t state;

  logic [COUNT_W-1:0] fill_count;
  logic [DIST_W-1:0]  max_distance;

  logic [COORD_WIDTH-1:0] qx, qy, qz;
  logic [COUNT_W-1:0]     cnt;

  logic               v1, v2, v3, v4;
  logic [ADDR_W-1:0]  i1, i2, i3, i4;
  logic [MAG_W-1:0]   mx, my, mz;
  logic [SQ_W-1:0]    sx, sy, sz;
  logic [DIST_W-1:0]  sq_dist;

  logic [DIST_W-1:0]  best;
  logic               best_found;
  logic [ADDR_W-1:0]  best_index;

  logic               accept;
  logic               ram_we;
  logic [ADDR_W-1:0]  ram_waddr;
  logic               rd_en;
  logic [POINT_W-1:0] rdata;
  logic [COORD_WIDTH-1:0] rx, ry, rz;
  logic               scan_end;
  logic               is_full;
  logic               idx_ok;

  assign accept    = start && !busy;
  assign busy      = (state == ST_SCAN);
  assign is_full   = (fill_count >= COUNT_W'(TABLE_DEPTH));
  assign idx_ok    = (COUNT_W'(item.index) < fill_count);
  assign rd_en     = (state == ST_SCAN) && (cnt < fill_count);
  assign scan_end  = (state == ST_SCAN) && !rd_en && !v1 && !v2 && !v3 && !v4;
  assign {rx, ry, rz} = rdata;

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = fill_count[ADDR_W-1:0];
    if (accept) begin
      unique case (func_t'(item.func)) inside
        FUNC_APPEND: begin
          ram_we = !is_full;
        end
        FUNC_REPLACE: begin
          ram_we    = idx_ok;
          ram_waddr = ADDR_W'(item.index);
        end
        FUNC_QUERY, FUNC_NONE: begin
          ram_we = 1'b0;
        end
        default: begin
          ram_we = 1'b0;
        end
      endcase
    end
  end

  npts_ram #(
    .WIDTH(POINT_W),
    .DEPTH(TABLE_DEPTH)
  ) u_points (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata({item.pos_x, item.pos_y, item.pos_z}),
    .re   (rd_en),
    .raddr(cnt[ADDR_W-1:0]),
    .rdata(rdata)
  );

  // distance pipeline, payload only
  always_ff @(posedge clk) begin
    i1 <= cnt[ADDR_W-1:0];
    i2 <= i1;
    mx <= abs_diff(rx, qx);
    my <= abs_diff(ry, qy);
    mz <= abs_diff(rz, qz);
    i3 <= i2;
    sx <= SQ_W'(mx) * SQ_W'(mx);
    sy <= SQ_W'(my) * SQ_W'(my);
    sz <= SQ_W'(mz) * SQ_W'(mz);
    i4 <= i3;
    sq_dist <= sum_sat(sx, sy, sz);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      fill_count   <= '0;
      max_distance <= MAX_DIST_RESET;
      cnt          <= '0;
      v1           <= 1'b0;
      v2           <= 1'b0;
      v3           <= 1'b0;
      v4           <= 1'b0;
      done         <= 1'b0;
    end else begin
      done <= 1'b0;
      v1   <= rd_en;
      v2   <= v1;
      v3   <= v2;
      v4   <= v3;
      if (max_dist_we) begin
        max_distance <= max_dist_wdata;
      end
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            result.status        <= STAT_OK;
            result.found         <= 1'b0;
            result.found_index   <= '0;
            result.best_distance <= '0;
            result.entry_count   <= ENTRY_W'(fill_count);
            unique case (func_t'(item.func))
              FUNC_APPEND: begin
                done <= 1'b1;
                if (is_full) begin
                  result.status <= STAT_FULL;
                end else begin
                  fill_count         <= fill_count + COUNT_W'(1);
                  result.entry_count <= ENTRY_W'(fill_count + COUNT_W'(1));
                end
              end
              FUNC_REPLACE: begin
                done <= 1'b1;
                if (!idx_ok) begin
                  result.status <= STAT_RANGE;
                end
              end
              FUNC_QUERY: begin
                state      <= ST_SCAN;
                cnt        <= '0;
                qx         <= item.pos_x;
                qy         <= item.pos_y;
                qz         <= item.pos_z;
                best       <= max_distance;
                best_found <= 1'b0;
                best_index <= '0;
              end
              FUNC_NONE: begin
                done <= 1'b1;
              end
              default: begin
                done <= 1'b1;
              end
            endcase
          end
        end
        ST_SCAN: begin
          if (rd_en) begin
            cnt <= cnt + COUNT_W'(1);
          end
          if (v4 && (best > sq_dist)) begin
            best       <= sq_dist;
            best_found <= 1'b1;
            best_index <= i4;
          end
          if (scan_end) begin
            state                <= ST_IDLE;
            done                 <= 1'b1;
            result.status        <= STAT_OK;
            result.found         <= best_found;
            result.found_index   <= INDEX_W'(best_index);
            result.best_distance <= best;
            result.entry_count   <= ENTRY_W'(fill_count);
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

/* design/npts_ram.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// npts_ram
// Simple dual port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module npts_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

/* design/npts_checker.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// npts_checker
// Port level checks for nearest_point_table_search, bound to the top level.
// ----------------------------------------------------------------------------
module npts_checker (
  input wire logic                      clk,
  input wire logic                      rst,
  input wire logic                      start,
  input wire logic                      busy,
  input wire npts_pkg::in_word_t        item,
  input wire logic                      done,
  input wire npts_pkg::out_word_t       result
);

  import npts_pkg::*;

  a_done_not_busy : assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result strobe while busy");

  a_query_busy : assert property (@(posedge clk) disable iff (rst)
    (start && !busy && item.func == FUNC_QUERY) |=> busy)
    else $error("query did not start a scan");

  a_simple_done : assert property (@(posedge clk) disable iff (rst)
    (start && !busy && item.func != FUNC_QUERY) |=> (done && !busy))
    else $error("non-query word did not finish in one cycle");

  a_not_found_zero : assert property (@(posedge clk) disable iff (rst)
    (done && !result.found) |-> (result.found_index == '0))
    else $error("found_index set without a hit");

  a_count_bound : assert property (@(posedge clk) disable iff (rst)
    done |-> (result.entry_count <= ENTRY_W'(TABLE_DEPTH)))
    else $error("entry_count beyond table depth");

endmodule

bind nearest_point_table_search npts_checker u_npts_checker (
  .clk   (clk),
  .rst   (rst),
  .start (start),
  .busy  (busy),
  .item  (item),
  .done  (done),
  .result(result)
);
`default_nettype wire

/* bench/nearest_point_table_search_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nearest_point_table_search_tb
// Drives appends, replaces, queries and unused codes into the point table
// and checks every result word against a shadow copy of the table kept here.
// The limit register is changed between phases while the block is idle.
// ----------------------------------------------------------------------------
module nearest_point_table_search_tb;
  import npts_pkg::*;

  localparam int WATCHDOG = 4000;

  class point_table_shadow;
    logic signed [COORD_WIDTH-1:0] px [TABLE_DEPTH];
    logic signed [COORD_WIDTH-1:0] py [TABLE_DEPTH];
    logic signed [COORD_WIDTH-1:0] pz [TABLE_DEPTH];
    int unsigned                   fill;
    logic [DIST_W-1:0]             limit;
    out_word_t                     due_words[$];
    int unsigned                   errors;

    function new();
      fill   = 0;
      limit  = MAX_DIST_RESET;
      errors = 0;
    endfunction

    function longint sq_term(logic signed [COORD_WIDTH-1:0] a,
                             logic signed [COORD_WIDTH-1:0] b);
      longint d;
      d = longint'(a) - longint'(b);
      if (d < 0) d = -d;
      if (d >= (longint'(1) << 25)) return longint'(DIST_MAX);
      d = d * d;
      return (d > longint'(DIST_MAX)) ? longint'(DIST_MAX) : d;
    endfunction

    function longint sat_add(longint a, longint b);
      longint s;
      s = a + b;
      return (s > longint'(DIST_MAX)) ? longint'(DIST_MAX) : s;
    endfunction

    function void record_item(in_word_t w);
      out_word_t want;
      longint    best;
      longint    d;
      want = '0;
      want.status = STAT_OK;
      case (func_t'(w.func))
        FUNC_APPEND: begin
          if (fill >= TABLE_DEPTH) begin
            want.status = STAT_FULL;
          end else begin
            px[fill] = w.pos_x;
            py[fill] = w.pos_y;
            pz[fill] = w.pos_z;
            fill++;
          end
        end
        FUNC_REPLACE: begin
          if (w.index >= fill) begin
            want.status = STAT_RANGE;
          end else begin
            px[w.index] = w.pos_x;
            py[w.index] = w.pos_y;
            pz[w.index] = w.pos_z;
          end
        end
        FUNC_QUERY: begin
          best = longint'(limit);
          for (int i = 0; i < fill; i++) begin
            d = sat_add(sat_add(sq_term(px[i], w.pos_x), sq_term(py[i], w.pos_y)),
                        sq_term(pz[i], w.pos_z));
            if (best > d) begin
              best = d;
              want.found = 1'b1;
              want.found_index = INDEX_W'(i);
            end
          end
          want.best_distance = DIST_W'(best);
        end
        default: ;
      endcase
      want.entry_count = ENTRY_W'(fill);
      due_words.push_back(want);
    endfunction

    function void flag(string field, logic [63:0] want, logic [63:0] got);
      errors++;
      if (errors <= 30)
        $display("%0t: %s mismatch: expected %0d, got %0d", $time, field, want, got);
    endfunction

    function void compare_word(out_word_t got);
      out_word_t want;
      if (due_words.size() == 0) begin
        errors++;
        $display("%0t: unexpected result word: expected none, got %h", $time, got);
        return;
      end
      want = due_words.pop_front();
      if (got.status !== want.status) flag("status", want.status, got.status);
      if (got.found !== want.found) flag("found", want.found, got.found);
      if (got.found_index !== want.found_index)
        flag("found_index", want.found_index, got.found_index);
      if (got.best_distance !== want.best_distance)
        flag("best_distance", want.best_distance, got.best_distance);
      if (got.entry_count !== want.entry_count)
        flag("entry_count", want.entry_count, got.entry_count);
    endfunction
  endclass

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              start = 1'b0;
  logic              busy;
  in_word_t          item_word = '0;
  logic              done;
  out_word_t         result_word;
  logic              max_dist_we = 1'b0;
  logic [DIST_W-1:0] max_dist_wdata = '0;

  point_table_shadow shadow = new();
  int unsigned       quiet = 0;
  int unsigned       burst_left = 0;

  localparam logic signed [COORD_WIDTH-1:0] C_MIN  = {1'b1, {(COORD_WIDTH-1){1'b0}}};
  localparam logic signed [COORD_WIDTH-1:0] C_MAX  = {1'b0, {(COORD_WIDTH-1){1'b1}}};
  localparam logic signed [COORD_WIDTH-1:0] C_ZERO = '0;

  nearest_point_table_search dut (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .item          (item_word),
    .done          (done),
    .result        (result_word),
    .max_dist_we   (max_dist_we),
    .max_dist_wdata(max_dist_wdata)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (!rst && done) shadow.compare_word(result_word);
    if (rst || done || (start && !busy)) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
      if (quiet >= WATCHDOG) begin
        $display("nearest_point_table_search test failed");
        $finish;
      end
    end
  end

  function automatic in_word_t point_word(func_t f, logic [INDEX_W-1:0] idx,
                                          logic signed [COORD_WIDTH-1:0] x,
                                          logic signed [COORD_WIDTH-1:0] y,
                                          logic signed [COORD_WIDTH-1:0] z);
    in_word_t w;
    w.func  = f;
    w.index = idx;
    w.pos_x = x;
    w.pos_y = y;
    w.pos_z = z;
    return w;
  endfunction

  function automatic logic signed [COORD_WIDTH-1:0] rand_coord();
    int unsigned m;
    m = $urandom_range(0, 9);
    if (m == 0) return C_MIN;
    if (m == 1) return C_MAX;
    if (m < 5) return COORD_WIDTH'($urandom);
    return COORD_WIDTH'(int'($urandom_range(0, 4095)) - 2048);
  endfunction

  function automatic logic signed [COORD_WIDTH-1:0] jitter(
    logic signed [COORD_WIDTH-1:0] c);
    return c + COORD_WIDTH'(int'($urandom_range(0, 64)) - 32);
  endfunction

  function automatic in_word_t random_word(int unsigned append_pct);
    in_word_t    w;
    int unsigned roll;
    int unsigned j;
    w.index = INDEX_W'($urandom);
    w.pos_x = rand_coord();
    w.pos_y = rand_coord();
    w.pos_z = rand_coord();
    roll = $urandom_range(0, 99);
    if (roll < append_pct) begin
      w.func = FUNC_APPEND;
    end else if (roll < append_pct + (100 - append_pct) / 3) begin
      w.func = FUNC_REPLACE;
      if (shadow.fill > 0 && $urandom_range(0, 3) != 0)
        w.index = INDEX_W'($urandom_range(0, shadow.fill - 1));
    end else if (roll < 97) begin
      w.func = FUNC_QUERY;
      if (shadow.fill > 0 && $urandom_range(0, 1) == 1) begin
        j = $urandom_range(0, shadow.fill - 1);
        w.pos_x = jitter(shadow.px[j]);
        w.pos_y = jitter(shadow.py[j]);
        w.pos_z = jitter(shadow.pz[j]);
      end
    end else begin
      w.func = FUNC_NONE;
    end
    return w;
  endfunction

  task automatic issue(input in_word_t w);
    start     <= 1'b1;
    item_word <= w;
    do @(posedge clk); while (busy !== 1'b0);
    shadow.record_item(w);
  endtask

  // lower start and wait for every outstanding word
  task automatic drain();
    start <= 1'b0;
    do @(posedge clk); while (shadow.due_words.size() != 0);
    repeat (2) @(posedge clk);
  endtask

  task automatic pace();
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      start <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 50)
                                                : $urandom_range(0, 6);
    end
    if ($urandom_range(0, 40) == 0) drain();
  endtask

  task automatic write_limit(input logic [DIST_W-1:0] v);
    drain();
    max_dist_we    <= 1'b1;
    max_dist_wdata <= v;
    @(posedge clk);
    max_dist_we    <= 1'b0;
    shadow.limit = v;
    @(posedge clk);
  endtask

  task automatic issue_paced(input in_word_t w);
    issue(w);
    pace();
  endtask

  initial begin
    logic [DIST_W-1:0] limits [4];
    int unsigned       append_pcts [4];

    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // empty table, out of range replace, unused code
    issue_paced(point_word(FUNC_QUERY, 8'd0, C_ZERO, C_ZERO, C_ZERO));
    issue_paced(point_word(FUNC_REPLACE, 8'd0, C_MAX, C_MIN, C_ZERO));
    issue_paced(point_word(FUNC_NONE, 8'hff, C_MAX, C_MAX, C_MAX));
    issue_paced(point_word(FUNC_APPEND, 8'hff, C_MIN, C_MIN, C_MIN));
    issue_paced(point_word(FUNC_APPEND, 8'h00, C_MAX, C_MAX, C_MAX));
    issue_paced(point_word(FUNC_APPEND, 8'h00, C_ZERO, C_ZERO, C_ZERO));
    // duplicate point: first one must win the tie
    issue_paced(point_word(FUNC_APPEND, 8'h00, C_ZERO, C_ZERO, C_ZERO));
    issue_paced(point_word(FUNC_APPEND, 8'h00, C_MAX, C_MIN, C_ZERO));
    issue_paced(point_word(FUNC_QUERY, 8'h00, C_ZERO, C_ZERO, C_ZERO));
    issue_paced(point_word(FUNC_QUERY, 8'h00, C_MAX, C_MAX, C_MAX));
    issue_paced(point_word(FUNC_QUERY, 8'h00, C_MIN, C_MAX, C_ZERO));
    issue_paced(point_word(FUNC_REPLACE, 8'd1, 24'sd100, -24'sd100, 24'sd50));
    issue_paced(point_word(FUNC_REPLACE, 8'd5, C_ZERO, C_ZERO, C_ZERO));
    issue_paced(point_word(FUNC_REPLACE, 8'd255, C_ZERO, C_ZERO, C_ZERO));
    issue_paced(point_word(FUNC_QUERY, 8'h00, 24'sd100, -24'sd100, 24'sd51));
    issue_paced(point_word(FUNC_NONE, 8'h00, C_MIN, C_MIN, C_MIN));

    write_limit(DIST_MAX);
    issue_paced(point_word(FUNC_QUERY, 8'h00, C_MAX, C_MAX, C_MIN));
    write_limit('0);
    issue_paced(point_word(FUNC_QUERY, 8'h00, C_ZERO, C_ZERO, C_ZERO));
    // limit equal to the distance: strict compare, not found
    write_limit(DIST_W'(1));
    issue_paced(point_word(FUNC_QUERY, 8'h00, C_ZERO, C_ZERO, C_ZERO));
    issue_paced(point_word(FUNC_QUERY, 8'h00, 24'sd1, C_ZERO, C_ZERO));

    limits[0] = DIST_MAX;
    limits[1] = MAX_DIST_RESET;
    limits[2] = {18'($urandom), 32'($urandom)};
    limits[3] = DIST_W'(1 << 22) + DIST_W'($urandom_range(0, 1 << 20));
    append_pcts[0] = 70;
    append_pcts[1] = 50;
    append_pcts[2] = 40;
    append_pcts[3] = 40;

    for (int p = 0; p < 4; p++) begin
      write_limit(limits[p]);
      for (int n = 0; n < 160; n++) issue_paced(random_word(append_pcts[p]));
    end

    drain();
    repeat (8) @(posedge clk);
    if (shadow.errors == 0 && shadow.due_words.size() == 0) begin
      $display("nearest_point_table_search test passed");
    end else begin
      $display("nearest_point_table_search test failed");
    end
    $finish;
  end

endmodule
